// ----- sv/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task scheduler table.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int ID_W   = 8;
   localparam int TIME_W = 32;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_ENABLE  = 2'd1,
      KIND_DISABLE = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MATCH,
      ST_DISP,
      ST_DONE
   } state_type;

   // One request as held during its processing.
   typedef struct packed {
      kind_type            kind;
      logic [ID_W-1:0]     task_id;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   now;
   } cmd_type;

   // One slot RAM entry.
   typedef struct packed {
      logic [TIME_W-1:0]   last_run;
      logic [TIME_W-1:0]   period;
      logic [ID_W-1:0]     task_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // One result handed to the response register.
   typedef struct packed {
      logic                valid;
      logic                status;
      logic                fired;
      logic [ID_W-1:0]     fired_id;
      logic                last;
   } emit_type;

endpackage

// ----- sv/pts_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_slot_ram
// Slot entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pts_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 72
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pts_scan_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_scan_ctrl
// Slot walk sequencer: used and enable marks, slot RAM read-modify-write,
// and ordering of the results of one request.
// ----------------------------------------------------------------------------
module pts_scan_ctrl
   import pts_pkg::*;
#(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cmd_type          cmd,
   input  logic             out_free,
   output logic             idle,
   output emit_type         emit,
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr,
   input  entry_type        rd_data,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output entry_type        wr_data
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] enabled_ff, enabled_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic             fin_status_ff, fin_status_in;

   logic              issue_more;
   logic [IDX_W-1:0]  issue_idx;
   logic [TIME_W-1:0] elapsed;
   logic              due;
   logic              match;
   logic              stall;

   assign issue_more = (issue_ff != CNT_W'(SLOTS));
   assign issue_idx  = issue_ff[IDX_W-1:0];
   assign elapsed    = cmd.now - rd_data.last_run;
   assign due        = ev_valid_ff && used_ff[ev_idx_ff] && enabled_ff[ev_idx_ff]
                       && (elapsed >= rd_data.period);
   assign match      = ev_valid_ff && used_ff[ev_idx_ff] && (rd_data.task_id == cmd.task_id);
   // a second due slot needs the response register to push the held one
   assign stall      = (state_ff == ST_DISP) && due && pend_valid_ff && !out_free;
   assign idle       = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd.kind) inside
                  KIND_ADD:                  state_in = ST_ADD;
                  KIND_ENABLE, KIND_DISABLE: state_in = ST_MATCH;
                  KIND_TICK:                 state_in = ST_DISP;
                  default:                   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (!issue_more || !used_ff[issue_idx]) begin
               state_in = ST_DONE;
            end
         end
         ST_MATCH, ST_DISP: begin
            if (!issue_more && !ev_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      issue_in      = issue_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      used_in       = used_ff;
      enabled_in    = enabled_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      fin_status_in = fin_status_ff;
      emit          = '0;
      rd_en         = 1'b0;
      rd_addr       = issue_idx;
      wr_en         = 1'b0;
      wr_addr       = ev_idx_ff;
      wr_data       = rd_data;
      wr_data.last_run = cmd.now;

      unique case (state_ff)
         ST_IDLE: begin
            issue_in      = '0;
            ev_valid_in   = 1'b0;
            pend_valid_in = 1'b0;
            fin_status_in = 1'b0;
         end
         ST_ADD: begin
            if (!issue_more) begin
               fin_status_in = 1'b1;
            end else if (!used_ff[issue_idx]) begin
               wr_en                 = 1'b1;
               wr_addr               = issue_idx;
               wr_data.task_id       = cmd.task_id;
               wr_data.period        = cmd.period;
               used_in[issue_idx]    = 1'b1;
               enabled_in[issue_idx] = 1'b0;
            end else begin
               issue_in = issue_ff + CNT_W'(1);
            end
         end
         ST_MATCH, ST_DISP: begin
            if (!stall) begin
               // read slot issue_ff while slot ev_idx_ff is evaluated and written
               if (issue_more) begin
                  rd_en       = 1'b1;
                  issue_in    = issue_ff + CNT_W'(1);
                  ev_valid_in = 1'b1;
                  ev_idx_in   = issue_idx;
               end else begin
                  ev_valid_in = 1'b0;
               end
               if (state_ff == ST_MATCH) begin
                  if (match) begin
                     wr_en                 = 1'b1;
                     enabled_in[ev_idx_ff] = (cmd.kind == KIND_ENABLE);
                  end
               end else if (due) begin
                  wr_en = 1'b1;
                  if (pend_valid_ff) begin
                     emit.valid    = 1'b1;
                     emit.fired    = 1'b1;
                     emit.fired_id = pend_id_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_data.task_id;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit.valid    = 1'b1;
               emit.last     = 1'b1;
               emit.status   = fin_status_ff;
               emit.fired    = pend_valid_ff;
               emit.fired_id = pend_valid_ff ? pend_id_ff : '0;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            issue_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= '0;
         ev_valid_ff   <= 1'b0;
         used_ff       <= '0;
         enabled_ff    <= '0;
         pend_valid_ff <= 1'b0;
         fin_status_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         ev_valid_ff   <= ev_valid_in;
         used_ff       <= used_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         fin_status_ff <= fin_status_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff  <= ev_idx_in;
      pend_id_ff <= pend_id_in;
   end

endmodule

// ----- sv/periodic_task_scheduler_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_scheduler_table_unit
// Table of periodic task slots with add, enable, disable and dispatch.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the kind (add, enable,
// disable, dispatch tick), tdata the task id, period and current time.
// Results leave on the rsp_ stream: tuser flags error and fired, tdata the
// fired task id, tlast marks the final result of a request. Add, enable and
// disable give one result; a tick gives one result per due task in slot
// order, or a single empty result when nothing is due.
// Enable, disable and tick walk the slot RAM one slot per cycle through its
// single read port, apart from the tick pause below; add scans the used marks
// instead and stops at the first free slot. One request is processed at a
// time; a new one is accepted while the previous result still waits in rsp_.
// Reset clears the used and enable marks at once, so the table is empty in
// the next cycle and no clearing pass is needed. When rsp_tready is low the
// result holds, and a tick with several due tasks pauses its walk until
// the held result moves.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_table_unit
   import pts_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // task_id[7:0], period[39:8], now[71:40]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // fired_id[7:0]
   output logic [1:0]  rsp_tuser,   // status[0], fired[1]
   output logic        rsp_tlast
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   cmd_type          cmd_ff;
   logic             start_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   emit_type         rsp_ff;
   logic             req_xfer;
   logic             out_free;
   logic             idle;
   emit_type         emit;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;

   assign req_tready = idle && !start_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= req_xfer;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff.kind    <= kind_type'(req_tuser);
         cmd_ff.task_id <= req_tdata[7:0];
         cmd_ff.period  <= req_tdata[39:8];
         cmd_ff.now     <= req_tdata[71:40];
      end
      if (emit.valid) begin
         rsp_ff <= emit;
      end
   end

   pts_scan_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .cmd      (cmd_ff),
      .out_free (out_free),
      .idle     (idle),
      .emit     (emit),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   pts_slot_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.fired_id;
   assign rsp_tuser[0] = rsp_ff.status;
   assign rsp_tuser[1] = rsp_ff.fired;
   assign rsp_tlast    = rsp_ff.last;

endmodule

// ----- sv/pts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the scheduler table, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a result without a fired task is the only and final one of its request
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("non-fired result not final or carries an id");

   // a full table error never reports a fired task
   a_err_nofire: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("error result flagged as fired");

   // one request at a time: ready drops right after a transfer
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind periodic_task_scheduler_table_unit pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
